[rtl/core/dlr_pkg.sv]
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants of the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

  // Configuration register file
  localparam int unsigned LIMIT_BITS   = 11;
  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT_LIMIT = 1'b1;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 11'd800;

  // Request kinds carried in tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[rtl/core/dlr_div.sv]
// ----------------------------------------------------------------------------
// dlr_div
// Restoring divider, one quotient bit per cycle; shared by both axes.
// ----------------------------------------------------------------------------
module dlr_div import dlr_pkg::*; #(
  parameter int unsigned N_BITS = 26,  // dividend and quotient width
  parameter int unsigned D_BITS = 10   // divisor width
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [N_BITS-1:0] dividend_i,
  input  logic [D_BITS-1:0] divisor_i,
  output div_status_t       status_o,
  output logic [N_BITS-1:0] quotient_o
);

  localparam int unsigned CNT_BITS = $clog2(N_BITS + 1);

  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [D_BITS-1:0]   rem_q, rem_d;
  logic [N_BITS-1:0]   quo_q, quo_d;
  logic [D_BITS-1:0]   dvs_q, dvs_d;
  logic [D_BITS:0]     shifted;
  logic [D_BITS+1:0]   diff;

  // trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_q, quo_q[N_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CNT_BITS'(N_BITS);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_BITS'(1));
      if (!diff[D_BITS+1]) begin
        rem_d = diff[D_BITS-1:0];
        quo_d = {quo_q[N_BITS-2:0], 1'b1};
      end else begin
        rem_d = shifted[D_BITS-1:0];
        quo_d = {quo_q[N_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

[rtl/core/dda_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: load a segment, then stream its pixels on request.
// ----------------------------------------------------------------------------
// A step request (tuser = 1) needs no division, and step requests may
// follow back to back; each one with a line pending emits the floor of the
// accumulators, an in-image flag and a last mark. A load request (tuser = 0)
// of a non-zero line computes both fixed-point increments on one shared
// restoring divider, one quotient bit per cycle, x first and then y, and the
// block takes no request until both are done; a zero-length load starts no
// division. The result register is refilled in the same cycle that its pixel
// is taken, so a master side that stays ready, while step requests keep
// coming, sees one pixel per cycle; while a pixel waits, no request is taken.
module dda_line_rasterizer import dlr_pkg::*; #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [LIMIT_BITS-1:0]   cfg_wdata_i,
  // request stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // start_x, start_y, end_x, end_y, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // req_type
  input  logic                 s_axis_tuser_i,
  // pixel stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // pixel_x, pixel_y, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // in_image
  output logic                 m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  localparam int unsigned C        = COORD_BITS;
  localparam int unsigned F        = FRAC_BITS;
  localparam int unsigned ACC_BITS = C + F;
  localparam int unsigned INC_BITS = F + 2;
  localparam int unsigned DIV_N    = C + F;
  localparam int unsigned OUT_W    = ((2*COORD_BITS+7)/8)*8;
  localparam int unsigned CMP_BITS = (C > LIMIT_BITS) ? C : LIMIT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } state_e;

  state_e                state_q, state_d;
  logic [LIMIT_BITS-1:0] width_q, height_q;
  logic [ACC_BITS-1:0]   acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [INC_BITS-1:0]   inc_x_q, inc_x_d, inc_y_q, inc_y_d;
  logic [C-1:0]          left_q, left_d;
  logic [C-1:0]          mag_y_q, mag_y_d;
  logic                  neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [C-1:0]          steps_q, steps_d;
  logic                  ovld_q, ovld_d;
  logic [C-1:0]          opx_q, opx_d, opy_q, opy_d;
  logic                  oin_q, oin_d, olast_q, olast_d;

  logic [C-1:0]     sx, sy, ex, ey, adx, ady, steps;
  logic [C-1:0]     px, py;
  logic             s_xfer, step_xfer, load_xfer;
  logic             div_start;
  logic [DIV_N-1:0] div_dividend, div_quo;
  div_status_t      div_st;
  logic [F:0]       quo_mag;
  logic [INC_BITS-1:0] quo_pos, quo_neg;

  assign sx = s_axis_tdata_i[C-1:0];
  assign sy = s_axis_tdata_i[2*C-1:C];
  assign ex = s_axis_tdata_i[3*C-1:2*C];
  assign ey = s_axis_tdata_i[4*C-1:3*C];

  assign adx   = (ex >= sx) ? (ex - sx) : (sx - ex);
  assign ady   = (ey >= sy) ? (ey - sy) : (sy - ey);
  assign steps = (adx > ady) ? adx : ady;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!ovld_q || m_axis_tready_i);
  assign s_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_xfer = s_xfer && (s_axis_tuser_i == REQ_LOAD);
  assign step_xfer = s_xfer && (s_axis_tuser_i == REQ_STEP);

  assign px = acc_x_q[ACC_BITS-1:F];
  assign py = acc_y_q[ACC_BITS-1:F];

  // magnitude fits in F+1 bits since |d| <= steps
  assign quo_mag = div_quo[F:0];
  assign quo_pos = {1'b0, quo_mag};
  assign quo_neg = '0 - quo_pos;

  always_comb begin
    state_d      = state_q;
    acc_x_d      = acc_x_q;
    acc_y_d      = acc_y_q;
    inc_x_d      = inc_x_q;
    inc_y_d      = inc_y_q;
    left_d       = left_q;
    mag_y_d      = mag_y_q;
    neg_x_d      = neg_x_q;
    neg_y_d      = neg_y_q;
    steps_d      = steps_q;
    ovld_d       = ovld_q && !m_axis_tready_i;
    opx_d        = opx_q;
    opy_d        = opy_q;
    oin_d        = oin_q;
    olast_d      = olast_q;
    div_start    = 1'b0;
    div_dividend = {adx, {F{1'b0}}};

    case (state_q)
      ST_IDLE: begin
        if (load_xfer) begin
          acc_x_d = {sx, {F{1'b0}}};
          acc_y_d = {sy, {F{1'b0}}};
          left_d  = steps;
          steps_d = steps;
          mag_y_d = ady;
          neg_x_d = (ex < sx);
          neg_y_d = (ey < sy);
          inc_x_d = '0;
          inc_y_d = '0;
          if (steps != '0) begin
            div_start = 1'b1;
            state_d   = ST_DIV_X;
          end
        end else if (step_xfer && (left_q != '0)) begin
          ovld_d  = 1'b1;
          opx_d   = px;
          opy_d   = py;
          oin_d   = (CMP_BITS'(px) < CMP_BITS'(width_q)) &&
                    (CMP_BITS'(py) < CMP_BITS'(height_q));
          olast_d = (left_q == C'(1));
          acc_x_d = acc_x_q + {{(C-2){inc_x_q[INC_BITS-1]}}, inc_x_q};
          acc_y_d = acc_y_q + {{(C-2){inc_y_q[INC_BITS-1]}}, inc_y_q};
          left_d  = left_q - 1'b1;
        end
      end
      ST_DIV_X: begin
        div_dividend = {mag_y_q, {F{1'b0}}};
        if (div_st.done) begin
          inc_x_d   = neg_x_q ? quo_neg : quo_pos;
          div_start = 1'b1;
          state_d   = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_st.done) begin
          inc_y_d = neg_y_q ? quo_neg : quo_pos;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  dlr_div #(
    .N_BITS (DIV_N),
    .D_BITS (C)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  ((state_q == ST_IDLE) ? steps : steps_q),
    .status_o   (div_st),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      width_q  <= LIMIT_RESET;
      height_q <= LIMIT_RESET;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
      inc_x_q  <= '0;
      inc_y_q  <= '0;
      left_q   <= '0;
      ovld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
      inc_x_q <= inc_x_d;
      inc_y_q <= inc_y_d;
      left_q  <= left_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH_LIMIT:  width_q  <= cfg_wdata_i;
          REG_HEIGHT_LIMIT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_y_q <= mag_y_d;
    neg_x_q <= neg_x_d;
    neg_y_q <= neg_y_d;
    steps_q <= steps_d;
    opx_q   <= opx_d;
    opy_q   <= opy_d;
    oin_q   <= oin_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = OUT_W'({opy_q, opx_q});
  assign m_axis_tuser_o  = oin_q;
  assign m_axis_tlast_o  = olast_q;

  // no request is taken while the divider works
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> !s_axis_tready_o)
    else $error("request accepted during division");

  // increments never exceed 1.0 in magnitude
  a_inc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (div_quo[DIV_N-1:F+1] == '0))
    else $error("increment magnitude above one");

  // the final pending step yields a pixel marked last
  a_last_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_xfer && (left_q == C'(1))) |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("final pixel not marked last");

  // a pixel only comes from a step request with a line pending
  a_pixel_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(step_xfer && (left_q != '0)))
    else $error("pixel emitted without a pending step");

endmodule

[test/dda_line_rasterizer_test.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer_test
// Self-checking bench for the DDA line rasterizer: loads and step requests go
// in on the request stream, a cycle-free model of the DDA predicts each pixel,
// and every pixel transfer is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_test import dlr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS   = 10;
  localparam int FRAC_BITS    = 16;
  localparam int ACC_W        = COORD_BITS + FRAC_BITS + 1;
  localparam int INC_W        = FRAC_BITS + 2;
  // divider latency of a load plus some slack
  localparam int DRAIN_CYCLES = 2 * (COORD_BITS + FRAC_BITS) + 12;
  localparam int CYCLE_LIMIT  = 400000;

  // last declared field, start_x, in the lowest bits
  typedef struct packed {
    logic [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] start_x;
  } seg_t;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  in_img;
    logic                  last;
  } pixel_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [LIMIT_BITS-1:0]   cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  seg_t        s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  dda_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // DDA state as the block should hold it
  logic signed [ACC_W-1:0] line_acc_x, line_acc_y;
  logic signed [INC_W-1:0] line_inc_x, line_inc_y;
  logic [COORD_BITS:0]     pixels_left;
  logic [LIMIT_BITS-1:0]   width_lim, height_lim;

  pixel_t pixel_q[$];
  int     mismatch_cnt;
  int     src_idle_pct;
  int     sink_idle_pct;
  int     hold_id;
  int     hold_len;
  int     cycle_cnt;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [INC_W-1:0] dda_increment(int d, int steps);
    int mag, q;
    mag = (d < 0) ? -d : d;
    q   = (mag << FRAC_BITS) / steps;
    return INC_W'((d < 0) ? -q : q);
  endfunction

  function automatic logic [COORD_BITS-1:0] acc_floor(logic signed [ACC_W-1:0] a);
    return (a < 0) ? '0 : a[FRAC_BITS +: COORD_BITS];
  endfunction

  // advance the DDA by one accepted request, queueing the pixel it emits
  function automatic void rasterize_req(logic kind, seg_t seg);
    int sx, sy, ex, ey, adx, ady, steps;
    pixel_t px;
    if (kind == REQ_LOAD) begin
      sx = seg.start_x;
      sy = seg.start_y;
      ex = seg.end_x;
      ey = seg.end_y;
      adx = (ex > sx) ? ex - sx : sx - ex;
      ady = (ey > sy) ? ey - sy : sy - ey;
      steps = (adx > ady) ? adx : ady;
      line_acc_x = {1'b0, seg.start_x, {FRAC_BITS{1'b0}}};
      line_acc_y = {1'b0, seg.start_y, {FRAC_BITS{1'b0}}};
      line_inc_x = (steps == 0) ? '0 : dda_increment(ex - sx, steps);
      line_inc_y = (steps == 0) ? '0 : dda_increment(ey - sy, steps);
      pixels_left = steps[COORD_BITS:0];
    end else if (pixels_left != 0) begin
      px.x      = acc_floor(line_acc_x);
      px.y      = acc_floor(line_acc_y);
      px.in_img = (px.x < width_lim) && (px.y < height_lim);
      px.last   = (pixels_left == 1);
      pixel_q.push_back(px);
      line_acc_x  = line_acc_x + line_inc_x;
      line_acc_y  = line_acc_y + line_inc_y;
      pixels_left = pixels_left - 1'b1;
    end
  endfunction

  function automatic seg_t random_seg();
    seg_t s;
    s.start_x = COORD_BITS'($urandom);
    s.start_y = COORD_BITS'($urandom);
    s.end_x   = COORD_BITS'($urandom);
    s.end_y   = COORD_BITS'($urandom);
    return s;
  endfunction

  // a coordinate within a dozen pixels of c, clamped to the grid
  function automatic logic [COORD_BITS-1:0] near_coord(logic [COORD_BITS-1:0] c);
    int ci, t, v;
    ci = c;
    t  = $urandom_range(24, 0);
    v  = ci + t - 12;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] error: %s", $time, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    pixel_t want, got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.x      = m_axis_tdata_o[COORD_BITS-1:0];
      got.y      = m_axis_tdata_o[2*COORD_BITS-1:COORD_BITS];
      got.in_img = m_axis_tuser_o;
      got.last   = m_axis_tlast_o;
      if (pixel_q.size() == 0) begin
        flag_mismatch($sformatf("pixel (%0d,%0d) with none pending", got.x, got.y));
      end else begin
        want = pixel_q.pop_front();
        if (got.x !== want.x)
          flag_mismatch($sformatf("pixel_x %0d, want %0d", got.x, want.x));
        if (got.y !== want.y)
          flag_mismatch($sformatf("pixel_y %0d, want %0d", got.y, want.y));
        if (got.in_img !== want.in_img)
          flag_mismatch($sformatf("in_image %0b, want %0b at (%0d,%0d)",
                                  got.in_img, want.in_img, want.x, want.y));
        if (got.last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b at (%0d,%0d)",
                                  got.last, want.last, want.x, want.y));
      end
    end
  end

  // pixel side: random back-pressure, plus long holds on request
  initial begin
    int hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_id) begin
        hold_seen = hold_id;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        m_axis_tready_i = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready_i = ($urandom_range(99, 0) >= sink_idle_pct);
      end
    end
  end

  task automatic send_req(input logic kind, input seg_t seg);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i  = random_seg();
      s_axis_tuser_i  = 1'($urandom_range(1, 0));
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = kind;
    s_axis_tdata_i  = seg;
    do @(posedge clk_i); while (!s_axis_tready_o);
    rasterize_req(kind, seg);
  endtask

  task automatic load_line(int sx, int sy, int ex, int ey);
    seg_t s;
    s.start_x = sx[COORD_BITS-1:0];
    s.start_y = sy[COORD_BITS-1:0];
    s.end_x   = ex[COORD_BITS-1:0];
    s.end_y   = ey[COORD_BITS-1:0];
    send_req(REQ_LOAD, s);
  endtask

  task automatic step_pixels(int n);
    repeat (n) send_req(REQ_STEP, random_seg());
  endtask

  // wait until every pixel is in and any load still in the divider is done
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [LIMIT_BITS-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_WIDTH_LIMIT) width_lim = val;
    else height_lim = val;
  endtask

  task automatic set_limits(int w, int h);
    drain();
    write_reg(REG_WIDTH_LIMIT, w[LIMIT_BITS-1:0]);
    write_reg(REG_HEIGHT_LIMIT, h[LIMIT_BITS-1:0]);
  endtask

  task automatic set_idling(int src, int sink);
    src_idle_pct  = src;
    sink_idle_pct = sink;
  endtask

  // reset limits, stray steps, zero length, bound crossing, far corners
  task automatic test_directed();
    step_pixels(1);
    load_line(0, 0, 0, 0);
    step_pixels(1);
    load_line(797, 798, 803, 801);
    step_pixels(7);
    load_line(0, 0, 1023, 1023);
    step_pixels(2);
    load_line(1023, 1023, 0, 0);
    step_pixels(2);
    load_line(1023, 0, 0, 1023);
    step_pixels(2);
    load_line(5, 1023, 8, 0);
    step_pixels(2);
    load_line(100, 200, 101, 200);
    step_pixels(2);
  endtask

  task automatic test_limit_extremes();
    set_limits(1, 1024);
    load_line(0, 1020, 2, 1023);
    step_pixels(3);
    set_limits(1024, 1);
    load_line(1020, 0, 1023, 2);
    step_pixels(3);
  endtask

  // mostly whole lines with random ends, some cut short, some stray steps
  task automatic test_random_lines(int budget);
    int sent, n, cnt, sx, sy, ex, ey;
    seg_t s;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99, 0) < 8) begin
        step_pixels(1);
      end else begin
        s = random_seg();
        if ($urandom_range(9, 0) != 0) begin
          s.end_x = near_coord(s.start_x);
          s.end_y = near_coord(s.start_y);
        end
        sx = s.start_x;
        sy = s.start_y;
        ex = s.end_x;
        ey = s.end_y;
        n = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > n) n = (ey > sy) ? ey - sy : sy - ey;
        if (n > 24) cnt = $urandom_range(12, 1);
        else if ($urandom_range(9, 0) < 7) cnt = n + $urandom_range(1, 0);
        else cnt = $urandom_range(n, 0);
        send_req(REQ_LOAD, s);
        step_pixels(cnt);
        sent += 1 + cnt;
      end
    end
  endtask

  // pixel side frozen while requests keep coming: the block must stall its input
  task automatic test_output_hold();
    set_idling(0, 0);
    hold_len = 300;
    hold_id++;
    load_line(10, 10, 60, 40);
    step_pixels(30);
    load_line(500, 700, 480, 660);
    step_pixels(25);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_WIDTH_LIMIT;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_LOAD;
    line_acc_x      = '0;
    line_acc_y      = '0;
    line_inc_x      = '0;
    line_inc_y      = '0;
    pixels_left     = '0;
    width_lim       = LIMIT_RESET;
    height_lim      = LIMIT_RESET;
    mismatch_cnt    = 0;
    hold_id         = 0;
    hold_len        = 0;
    cycle_cnt       = 0;
    set_idling(37, 61);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_limit_extremes();
    set_limits($urandom_range(1024, 1), $urandom_range(1024, 1));
    test_random_lines(200);
    drain();
    set_idling(61, 37);
    set_limits($urandom_range(1024, 1), $urandom_range(1024, 1));
    test_random_lines(200);
    drain();
    set_idling(0, 0);
    set_limits(800, 800);
    test_random_lines(170);
    test_output_hold();
    drain();

    if (pixel_q.size() != 0)
      flag_mismatch($sformatf("%0d pixels never arrived", pixel_q.size()));
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/dlr_pkg.sv
rtl/core/dlr_div.sv
rtl/core/dda_line_rasterizer.sv
test/dda_line_rasterizer_test.sv
